// ===== rtl/linear_blend_skinning_core_defines.svh =====
// Assertion macros for the linear blend skinning core.
// Used by the top level only; relies on clk_i and rst_ni being in scope.
`ifndef LINEAR_BLEND_SKINNING_CORE_DEFINES_SVH
`define LINEAR_BLEND_SKINNING_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LBS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LBS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lbs_pkg.sv =====
// Shared constants, types and saturation helpers for the skinning core.
// No dependencies; imported by every module of the block.
package lbs_pkg;

  // Matrix store geometry.
  localparam int BONE_COUNT      = 32;
  localparam int ELEMS_PER_BONE  = 12;
  localparam int MEM_DEPTH       = BONE_COUNT * ELEMS_PER_BONE;
  localparam int MEM_AW          = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // Stream widths.
  localparam int IN_TDATA_W  = 256;
  localparam int OUT_TDATA_W = 192;

  // Command carried in tuser.
  localparam logic CMD_MATRIX_WRITE = 1'b0;
  localparam logic CMD_INFLUENCE    = 1'b1;

  // Operation kinds that travel down the datapath pipeline.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_MV,   // matrix element times vector component
    OP_TR,   // add translation, saturate both rows
    OP_WP,   // weight times position row into accumulator
    OP_WN    // weight times normal row into accumulator
  } lbs_kind_e;

  typedef struct packed {
    lbs_kind_e   kind;
    logic        vec;   // 0 = position, 1 = normal
    logic [1:0]  c;     // matrix column
    logic [1:0]  row;   // matrix row
  } lbs_op_t;

  localparam lbs_op_t OP_IDLE = '{kind: OP_NOP, vec: 1'b0, c: 2'd0, row: 2'd0};

  // Sequencer to datapath control.
  typedef struct packed {
    logic        load;    // capture a new influence request
    logic [3:0]  rd_off;  // element offset within the bone, row*4+col
    lbs_op_t     op_b;    // operation in the multiply stage
    lbs_op_t     op_c;    // operation in the accumulate stage
    logic        emit;    // deliver result and clear accumulators
  } lbs_ctrl_t;

  // One input request.
  typedef struct packed {
    logic [4:0]         bone_index;
    logic [3:0]         elem_index;
    logic signed [31:0] elem_value;
    logic [16:0]        weight;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] nrm_x;
    logic signed [31:0] nrm_y;
    logic signed [31:0] nrm_z;
  } lbs_item_t;

  // One result.
  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_nrm_x;
    logic signed [31:0] out_nrm_y;
    logic signed [31:0] out_nrm_z;
  } lbs_res_t;

  // Saturate a 51-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    logic signed [31:0] r;
    if (!v[50] && (|v[49:31])) begin
      r = {1'b0, {31{1'b1}}};
    end else if (v[50] && !(&v[49:31])) begin
      r = {1'b1, {31{1'b0}}};
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Saturate a 49-bit signed value to 48 bits.
  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    logic signed [47:0] r;
    if (v[48] != v[47]) begin
      r = v[48] ? {1'b1, {47{1'b0}}} : {1'b0, {47{1'b1}}};
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/linear_blend_skinning_core.sv =====
// Channel  | dir | tdata                                   | tuser    | tlast
// s_axis   | in  | bone, elem, value, weight, pos, nrm     | command  | last influence
// m_axis   | out | skinned pos x/y/z, nrm x/y/z            | -        | -
//
// A matrix write request is taken and written to the store at its accept edge.
// An influence request keeps the input busy after its accept edge: 30 steps
// on the one 33x32 multiplier (9 operations per matrix row plus a gap), the
// pipeline drain state and the finish state, so no new request is taken before
// the sequencer is idle again; the single read port of the store sets the order.
// Reset clears control and accumulators only; matrix store words are undefined
// until written. The last influence of a vertex waits in its finish cycle while
// the output register still holds an undelivered result.
`include "linear_blend_skinning_core_defines.svh"

// Top level of the skinning core: stream ports, output register, assertions.
// Depends on lbs_pkg, lbs_seq and lbs_dp.
module linear_blend_skinning_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // bone_index, elem_index, elem_value, weight, pos_x, pos_y, pos_z,
  // nrm_x, nrm_y, nrm_z, zero padding
  input  logic [lbs_pkg::IN_TDATA_W-1:0]       s_axis_tdata_i,
  // command
  input  logic [0:0]                           s_axis_tuser_i,
  input  logic                                 s_axis_tlast_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y, out_nrm_z
  output logic [lbs_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o
);
  import lbs_pkg::*;

  lbs_item_t                item;
  lbs_ctrl_t                ctrl;
  lbs_res_t                 res;
  logic                     s_fire, inf_fire, idle, out_free;
  logic                     out_vld_q;
  logic [OUT_TDATA_W-1:0]   out_data_q;

  // Unpack the request.
  assign item.bone_index = s_axis_tdata_i[4:0];
  assign item.elem_index = s_axis_tdata_i[8:5];
  assign item.elem_value = s_axis_tdata_i[40:9];
  assign item.weight     = s_axis_tdata_i[57:41];
  assign item.pos_x      = s_axis_tdata_i[89:58];
  assign item.pos_y      = s_axis_tdata_i[121:90];
  assign item.pos_z      = s_axis_tdata_i[153:122];
  assign item.nrm_x      = s_axis_tdata_i[185:154];
  assign item.nrm_y      = s_axis_tdata_i[217:186];
  assign item.nrm_z      = s_axis_tdata_i[249:218];

  assign s_axis_tready_o = idle;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign inf_fire        = s_fire && (s_axis_tuser_i[0] == CMD_INFLUENCE);
  assign out_free        = !out_vld_q || m_axis_tready_i;

  lbs_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (inf_fire),
    .last_i     (s_axis_tlast_i),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .idle_o     (idle)
  );

  lbs_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (s_fire && (s_axis_tuser_i[0] == CMD_MATRIX_WRITE)),
    .item_i  (item),
    .ctrl_i  (ctrl),
    .res_o   (res)
  );

  // Output register; a new result loads only when the slot is free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      out_data_q <= {res.out_nrm_z, res.out_nrm_y, res.out_nrm_x,
                     res.out_pos_z, res.out_pos_y, res.out_pos_x};
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  // Checks on the sequencing.
  `LBS_ASSERT_NEXT(a_busy_after_influence, inf_fire, !s_axis_tready_o, "ready after influence")
  `LBS_ASSERT_NEXT(a_emit_shows_result, ctrl.emit, m_axis_tvalid_o, "result not presented")
  `LBS_ASSERT_IMPL(a_valid_from_emit, $rose(out_vld_q), $past(ctrl.emit), "valid without emit")

endmodule

// ===== rtl/lbs_seq.sv =====
// Sequencer of the skinning core: walks the 30 steps of one influence.
// Depends on lbs_pkg for the control struct and operation kinds.
module lbs_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              last_i,
  input  logic              out_free_i,
  output lbs_pkg::lbs_ctrl_t ctrl_o,
  output logic              idle_o
);
  import lbs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DRN  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  // Step positions within one matrix row.
  localparam logic [3:0] K_LAST_MV = 4'd5;
  localparam logic [3:0] K_TR      = 4'd6;
  localparam logic [3:0] K_GAP     = 4'd7;
  localparam logic [3:0] K_WP      = 4'd8;
  localparam logic [3:0] K_WN      = 4'd9;
  localparam logic [1:0] ROW_LAST  = 2'd2;
  localparam logic [3:0] DRN_LAST  = 4'd1;

  logic [1:0] state_q, state_d;
  logic [3:0] k_q, k_d;
  logic [1:0] row_q, row_d;
  logic       last_q, last_d;
  lbs_op_t    op_a, op_b_q, op_c_q;
  logic       emit;

  // Decode the operation issued in this cycle.
  always_comb begin
    op_a     = OP_IDLE;
    op_a.row = row_q;
    if (state_q == ST_RUN) begin
      if (k_q <= K_LAST_MV) begin
        op_a.kind = OP_MV;
        op_a.vec  = k_q[0];
        op_a.c    = k_q[2:1];
      end else begin
        case (k_q)
          K_TR: begin
            op_a.kind = OP_TR;
            op_a.c    = 2'd3;
          end
          K_GAP:   op_a.kind = OP_NOP;
          K_WP:    op_a.kind = OP_WP;
          K_WN:    op_a.kind = OP_WN;
          default: op_a.kind = OP_NOP;
        endcase
      end
    end
  end

  assign emit = (state_q == ST_FIN) && last_q && out_free_i;

  // Next state and step counters.
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    row_d   = row_q;
    last_d  = last_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_RUN;
          k_d     = '0;
          row_d   = '0;
          last_d  = last_i;
        end
      end
      ST_RUN: begin
        if (k_q == K_WN) begin
          k_d = '0;
          if (row_q == ROW_LAST) begin
            state_d = ST_DRN;
          end else begin
            row_d = row_q + 2'd1;
          end
        end else begin
          k_d = k_q + 4'd1;
        end
      end
      ST_DRN: begin
        if (k_q == DRN_LAST) begin
          state_d = ST_FIN;
          k_d     = '0;
        end else begin
          k_d = k_q + 4'd1;
        end
      end
      ST_FIN: begin
        if (!last_q || out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers and the operation pipeline tags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      row_q   <= '0;
      last_q  <= 1'b0;
      op_b_q  <= OP_IDLE;
      op_c_q  <= OP_IDLE;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      row_q   <= row_d;
      last_q  <= last_d;
      op_b_q  <= op_a;
      op_c_q  <= op_b_q;
    end
  end

  assign ctrl_o.load   = start_i && (state_q == ST_IDLE);
  assign ctrl_o.rd_off = {op_a.row, op_a.c};
  assign ctrl_o.op_b   = op_b_q;
  assign ctrl_o.op_c   = op_c_q;
  assign ctrl_o.emit   = emit;
  assign idle_o        = (state_q == ST_IDLE);

endmodule

// ===== rtl/lbs_dp.sv =====
// Datapath of the skinning core: matrix store, shared multiplier, row sums
// and accumulators. Depends on lbs_pkg; driven by lbs_seq.
module lbs_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  lbs_pkg::lbs_item_t item_i,
  input  lbs_pkg::lbs_ctrl_t ctrl_i,
  output lbs_pkg::lbs_res_t  res_o
);
  import lbs_pkg::*;

  logic signed [31:0] mem_q [MEM_DEPTH];
  logic signed [31:0] rdata_q;
  logic [MEM_AW-1:0]  bone_base, wr_addr, rd_addr, base_q;
  logic               bone_ok, elem_ok;

  logic [16:0]        w_q;
  logic signed [31:0] p_q [3];
  logic signed [31:0] n_q [3];
  logic               zero_q;

  logic signed [31:0] m_eff, vsel;
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] prod_q;
  logic signed [31:0] mcopy_q;

  logic signed [49:0] rowp_q, rown_q, mv_term;
  logic signed [31:0] psat_q, nsat_q;
  logic signed [48:0] w_term;
  logic signed [50:0] tr_sum;
  logic signed [47:0] acc_p_q [3];
  logic signed [47:0] acc_n_q [3];

  // Address of a bone's first element is bone * 12.
  assign bone_ok   = 32'(item_i.bone_index) < BONE_COUNT;
  assign elem_ok   = item_i.elem_index < 4'(ELEMS_PER_BONE);
  assign bone_base = MEM_AW'({item_i.bone_index, 3'b000})
                   + MEM_AW'({item_i.bone_index, 2'b00});
  assign wr_addr   = bone_base + MEM_AW'(item_i.elem_index);
  assign rd_addr   = base_q + MEM_AW'(ctrl_i.rd_off);

  // Matrix store: one write port from the request, one registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en_i && bone_ok && elem_ok) begin
      mem_q[wr_addr] <= item_i.elem_value;
    end
    rdata_q <= mem_q[rd_addr];
  end

  // Capture the influence request.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      w_q    <= item_i.weight;
      p_q[0] <= item_i.pos_x;
      p_q[1] <= item_i.pos_y;
      p_q[2] <= item_i.pos_z;
      n_q[0] <= item_i.nrm_x;
      n_q[1] <= item_i.nrm_y;
      n_q[2] <= item_i.nrm_z;
      base_q <= bone_ok ? bone_base : '0;
      zero_q <= !bone_ok;
    end
  end

  // Operand selection for the shared multiplier. A bone outside the store
  // behaves as an all-zero matrix.
  assign m_eff = zero_q ? '0 : rdata_q;

  always_comb begin
    case (ctrl_i.op_b.c)
      2'd0:    vsel = ctrl_i.op_b.vec ? n_q[0] : p_q[0];
      2'd1:    vsel = ctrl_i.op_b.vec ? n_q[1] : p_q[1];
      default: vsel = ctrl_i.op_b.vec ? n_q[2] : p_q[2];
    endcase
  end

  always_comb begin
    case (ctrl_i.op_b.kind)
      OP_WP: begin
        mul_a = $signed({16'd0, w_q});
        mul_b = psat_q;
      end
      OP_WN: begin
        mul_a = $signed({16'd0, w_q});
        mul_b = nsat_q;
      end
      default: begin
        mul_a = {m_eff[31], m_eff};
        mul_b = vsel;
      end
    endcase
  end

  // Multiply stage.
  always_ff @(posedge clk_i) begin
    prod_q  <= mul_a * mul_b;
    mcopy_q <= m_eff;
  end

  // Products shifted right by 16 with floor.
  assign mv_term = {{2{prod_q[63]}}, prod_q[63:16]};
  assign w_term  = {{16{prod_q[48]}}, prod_q[48:16]};
  assign tr_sum  = {rowp_q[49], rowp_q} + {{19{mcopy_q[31]}}, mcopy_q};

  // Row sums and their saturated values.
  always_ff @(posedge clk_i) begin
    case (ctrl_i.op_c.kind)
      OP_MV: begin
        if (ctrl_i.op_c.vec) begin
          rown_q <= (ctrl_i.op_c.c == 2'd0) ? mv_term : rown_q + mv_term;
        end else begin
          rowp_q <= (ctrl_i.op_c.c == 2'd0) ? mv_term : rowp_q + mv_term;
        end
      end
      OP_TR: begin
        psat_q <= sat32(tr_sum);
        nsat_q <= sat32({rown_q[49], rown_q});
      end
      default: ;
    endcase
  end

  // Accumulators, cleared when a result leaves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        acc_p_q[i] <= '0;
        acc_n_q[i] <= '0;
      end
    end else if (ctrl_i.emit) begin
      for (int i = 0; i < 3; i++) begin
        acc_p_q[i] <= '0;
        acc_n_q[i] <= '0;
      end
    end else begin
      case (ctrl_i.op_c.kind)
        OP_WP: acc_p_q[ctrl_i.op_c.row] <=
                 sat48({acc_p_q[ctrl_i.op_c.row][47], acc_p_q[ctrl_i.op_c.row]} + w_term);
        OP_WN: acc_n_q[ctrl_i.op_c.row] <=
                 sat48({acc_n_q[ctrl_i.op_c.row][47], acc_n_q[ctrl_i.op_c.row]} + w_term);
        default: ;
      endcase
    end
  end

  // Result, saturated to Q16.16.
  assign res_o.out_pos_x = sat32({{3{acc_p_q[0][47]}}, acc_p_q[0]});
  assign res_o.out_pos_y = sat32({{3{acc_p_q[1][47]}}, acc_p_q[1]});
  assign res_o.out_pos_z = sat32({{3{acc_p_q[2][47]}}, acc_p_q[2]});
  assign res_o.out_nrm_x = sat32({{3{acc_n_q[0][47]}}, acc_n_q[0]});
  assign res_o.out_nrm_y = sat32({{3{acc_n_q[1][47]}}, acc_n_q[1]});
  assign res_o.out_nrm_z = sat32({{3{acc_n_q[2][47]}}, acc_n_q[2]});

endmodule

// ===== dv/linear_blend_skinning_core_test.sv =====
// Self-checking testbench for linear_blend_skinning_core: directed table, then random
// bone loads and vertices, checked against a fixed-point skinning predictor.
// Depends on lbs_pkg and the core RTL only.
`timescale 1ns / 1ps

module linear_blend_skinning_core_test;
  import lbs_pkg::*;

  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint I32_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint I32_LO = -I32_HI - 1;
  localparam int N_DIRECTED = 23;
  localparam int RANDOM_ITEMS = 500;
  localparam int DRAIN_CYCLES = 100;

  // One input request in field form.
  typedef struct packed {
    logic               cmd;
    logic [4:0]         bone;
    logic [3:0]         elem;
    logic signed [31:0] value;
    logic [16:0]        weight;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] nrm_x;
    logic signed [31:0] nrm_y;
    logic signed [31:0] nrm_z;
    logic               last;
  } skin_req_t;

  // Directed row: request plus an optional hand-written result.
  typedef struct packed {
    skin_req_t req;
    logic      typed;
    lbs_res_t  want;
  } table_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]             s_axis_tuser = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Predictor state.
  logic signed [31:0] skin_store [BONE_COUNT*ELEMS_PER_BONE];
  longint             pos_acc [3];
  longint             nrm_acc [3];
  logic [11:0]        elems_written [BONE_COUNT];
  logic [BONE_COUNT-1:0] bone_ready = '0;

  lbs_res_t pending_vertices [$];
  int       mismatches = 0;
  int       burst_left = 0;
  string    field_names [6] = '{"out_pos_x", "out_pos_y", "out_pos_z",
                                "out_nrm_x", "out_nrm_y", "out_nrm_z"};

  linear_blend_skinning_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic skin_req_t wr(input int bone, input int elem,
                                   input logic signed [31:0] value, input logic last);
    skin_req_t r;
    r = '0;
    r.cmd   = CMD_MATRIX_WRITE;
    r.bone  = 5'(bone);
    r.elem  = 4'(elem);
    r.value = value;
    r.last  = last;
    return r;
  endfunction

  function automatic skin_req_t inf(input int bone, input int weight,
                                    input logic signed [31:0] px, py, pz, nx, ny, nz,
                                    input logic last);
    skin_req_t r;
    r = '0;
    r.cmd    = CMD_INFLUENCE;
    r.bone   = 5'(bone);
    r.weight = 17'(weight);
    r.pos_x  = px;
    r.pos_y  = py;
    r.pos_z  = pz;
    r.nrm_x  = nx;
    r.nrm_y  = ny;
    r.nrm_z  = nz;
    r.last   = last;
    return r;
  endfunction

  // Q16.16 values: mostly within a few units, sometimes extreme or fully random.
  function automatic logic signed [31:0] rand_fixed();
    case ($urandom_range(0, 9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return $urandom();
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  function automatic logic [16:0] rand_weight();
    case ($urandom_range(0, 9))
      0: return 17'h1_0000;
      1: return 17'($urandom_range(32'h1_0001, 32'h1_FFFF));
      2: return '0;
      default: return 17'($urandom_range(0, 32'hFFFF));
    endcase
  endfunction

  // Fields the command does not look at still carry random bits.
  function automatic skin_req_t fill_unused(input skin_req_t r);
    if (r.cmd == CMD_MATRIX_WRITE) begin
      r.weight = 17'($urandom_range(0, 32'h1_FFFF));
      r.pos_x  = $urandom();
      r.pos_y  = $urandom();
      r.pos_z  = $urandom();
      r.nrm_x  = $urandom();
      r.nrm_y  = $urandom();
      r.nrm_z  = $urandom();
    end else begin
      r.elem  = 4'($urandom_range(0, 15));
      r.value = $urandom();
    end
    return r;
  endfunction

  // Skinning predictor: updates the matrix store or the accumulators and
  // returns 1 with the saturated vertex when the last influence arrives.
  function automatic bit blend_influence(input skin_req_t r, output lbs_res_t vtx);
    longint pvec [3];
    longint nvec [3];
    longint prow, nrow, m, w;
    int     base;
    vtx = '0;
    base = r.bone * ELEMS_PER_BONE;
    if (r.cmd == CMD_MATRIX_WRITE) begin
      if (r.bone < BONE_COUNT && r.elem < ELEMS_PER_BONE) begin
        skin_store[base + r.elem] = r.value;
      end
      return 1'b0;
    end
    pvec[0] = longint'(r.pos_x);
    pvec[1] = longint'(r.pos_y);
    pvec[2] = longint'(r.pos_z);
    nvec[0] = longint'(r.nrm_x);
    nvec[1] = longint'(r.nrm_y);
    nvec[2] = longint'(r.nrm_z);
    w = longint'(r.weight);
    for (int row = 0; row < 3; row++) begin
      prow = 0;
      nrow = 0;
      for (int c = 0; c < 3; c++) begin
        m = (r.bone < BONE_COUNT) ? longint'(skin_store[base + row*4 + c]) : 0;
        prow += (m * pvec[c]) >>> 16;
        nrow += (m * nvec[c]) >>> 16;
      end
      // Position gets the translation column; the normal does not.
      prow += (r.bone < BONE_COUNT) ? longint'(skin_store[base + row*4 + 3]) : 0;
      prow = clamp(prow, I32_LO, I32_HI);
      nrow = clamp(nrow, I32_LO, I32_HI);
      pos_acc[row] = clamp(pos_acc[row] + ((w * prow) >>> 16), ACC_LO, ACC_HI);
      nrm_acc[row] = clamp(nrm_acc[row] + ((w * nrow) >>> 16), ACC_LO, ACC_HI);
    end
    if (!r.last) return 1'b0;
    vtx.out_pos_x = 32'(clamp(pos_acc[0], I32_LO, I32_HI));
    vtx.out_pos_y = 32'(clamp(pos_acc[1], I32_LO, I32_HI));
    vtx.out_pos_z = 32'(clamp(pos_acc[2], I32_LO, I32_HI));
    vtx.out_nrm_x = 32'(clamp(nrm_acc[0], I32_LO, I32_HI));
    vtx.out_nrm_y = 32'(clamp(nrm_acc[1], I32_LO, I32_HI));
    vtx.out_nrm_z = 32'(clamp(nrm_acc[2], I32_LO, I32_HI));
    for (int k = 0; k < 3; k++) begin
      pos_acc[k] = 0;
      nrm_acc[k] = 0;
    end
    return 1'b1;
  endfunction

  // Drive one request in bursts with random gaps, wait for its handshake,
  // then update the predictor and queue the expected vertex.
  task automatic send_request(input skin_req_t r, input logic typed, input lbs_res_t want);
    logic     took;
    lbs_res_t vtx;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                : $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, r.nrm_z, r.nrm_y, r.nrm_x, r.pos_z, r.pos_y, r.pos_x,
                      r.weight, r.value, r.elem, r.bone};
    s_axis_tuser  <= r.cmd;
    s_axis_tlast  <= r.last;
    took = 1'b0;
    while (!took) begin
      @(negedge clk_i);
      took = s_axis_tready;
      @(posedge clk_i);
    end
    if (r.cmd == CMD_MATRIX_WRITE && r.elem < ELEMS_PER_BONE) begin
      elems_written[r.bone][r.elem] = 1'b1;
      if (&elems_written[r.bone]) bone_ready[r.bone] = 1'b1;
    end
    if (blend_influence(r, vtx)) pending_vertices = {pending_vertices, (typed ? want : vtx)};
  endtask

  // Receiver stalls: always ready, coin flip, or mostly stalled, in spans.
  int stall_mode = 0;
  int stall_span = 0;
  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_span <= $urandom_range(20, 200);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // Sample the result channel mid-cycle; the transfer happens at the next rising edge.
  logic                   out_take = 1'b0;
  logic [OUT_TDATA_W-1:0] out_word;
  always @(negedge clk_i) begin
    out_take = rst_ni && m_axis_tvalid && m_axis_tready;
    out_word = m_axis_tdata;
  end

  // Compare each delivered vertex with the oldest expectation.
  always @(posedge clk_i) begin
    lbs_res_t           want;
    logic signed [31:0] exp_f [6];
    if (out_take) begin
      if (pending_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected vertex: %h", out_word);
      end else begin
        want = pending_vertices.pop_front();
        exp_f = '{want.out_pos_x, want.out_pos_y, want.out_pos_z,
                  want.out_nrm_x, want.out_nrm_y, want.out_nrm_z};
        for (int k = 0; k < 6; k++) begin
          if (out_word[32*k +: 32] !== exp_f[k]) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%s mismatch: expected %h, got %h", field_names[k], exp_f[k],
                       out_word[32*k +: 32]);
            end
          end
        end
      end
    end
  end

  // Stimulus.
  initial begin
    table_row_t directed [N_DIRECTED];
    skin_req_t  r;
    int         items;
    int         bone;
    int         n_inf;
    int         choice;

    for (int i = 0; i < BONE_COUNT*ELEMS_PER_BONE; i++) skin_store[i] = '0;
    for (int i = 0; i < BONE_COUNT; i++) elems_written[i] = '0;
    for (int k = 0; k < 3; k++) begin
      pos_acc[k] = 0;
      nrm_acc[k] = 0;
    end

    // Bone 0: identity rotation, translation (0.5, 0, -1).
    for (int e = 0; e < ELEMS_PER_BONE; e++) begin
      directed[e] = '{wr(0, e, (e == 0 || e == 5 || e == 10) ? Q_ONE : 32'sh0, 1'b0),
                      1'b0, '0};
    end
    directed[3]  = '{wr(0, 3, 32'sh0000_8000, 1'b0), 1'b0, '0};
    directed[11] = '{wr(0, 11, -Q_ONE, 1'b0), 1'b0, '0};
    // First vertex after reset, unit weight: a plain affine transform.
    directed[12] = '{inf(0, 32'h1_0000, Q_ONE, 2*Q_ONE, 3*Q_ONE, 0, Q_ONE, 0, 1'b1), 1'b1,
                     '{32'sh1_8000, 32'sh2_0000, 32'sh2_0000, 32'sh0, Q_ONE, 32'sh0}};
    // Element index beyond the matrix is dropped; a write ignores the last mark.
    directed[13] = '{wr(0, 12, Q_MAX, 1'b1), 1'b0, '0};
    directed[14] = '{wr(0, 15, Q_MIN, 1'b0), 1'b0, '0};
    directed[15] = directed[12];
    // Weight above one and extreme vectors, accumulated three times.
    directed[16] = '{inf(0, 32'h1_FFFF, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 1'b0),
                     1'b0, '0};
    directed[17] = directed[16];
    directed[18] = directed[16];
    directed[18].req.last = 1'b1;
    // Extreme matrix elements.
    directed[19] = '{wr(0, 0, Q_MIN, 1'b0), 1'b0, '0};
    directed[20] = '{wr(0, 5, Q_MAX, 1'b1), 1'b0, '0};
    directed[21] = '{inf(0, 1, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b1), 1'b0, '0};
    // Zero weight contributes nothing.
    directed[22] = '{inf(0, 0, Q_MAX, Q_MIN, Q_ONE, Q_MIN, Q_MAX, Q_ONE, 1'b1), 1'b1, '0};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_request(directed[i].req, directed[i].typed, directed[i].want);
    end

    // Random part: bone loads, vertices of one to four influences, and noise.
    items = 0;
    while (items < RANDOM_ITEMS) begin
      choice = $urandom_range(0, 99);
      if (choice < 8) begin
        bone = $urandom_range(0, BONE_COUNT - 1);
        for (int e = 0; e < ELEMS_PER_BONE; e++) begin
          r = wr(bone, e, ($urandom_range(0, 9) == 0) ? rand_fixed()
                 : $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000,
                 1'($urandom_range(0, 1)));
          send_request(fill_unused(r), 1'b0, '0);
          items++;
        end
      end else if (choice < 20) begin
        // Stray writes: out-of-range elements or single element updates.
        r = wr($urandom_range(0, BONE_COUNT - 1),
               ($urandom_range(0, 1) == 0) ? $urandom_range(12, 15) : $urandom_range(0, 11),
               rand_fixed(), 1'($urandom_range(0, 1)));
        send_request(fill_unused(r), 1'b0, '0);
        items++;
      end else begin
        n_inf = $urandom_range(1, 4);
        for (int k = 0; k < n_inf; k++) begin
          bone = $urandom_range(0, BONE_COUNT - 1);
          while (!bone_ready[bone]) bone = $urandom_range(0, BONE_COUNT - 1);
          r = inf(bone, int'(rand_weight()), rand_fixed(), rand_fixed(), rand_fixed(),
                  rand_fixed(), rand_fixed(), rand_fixed(), k == n_inf - 1);
          send_request(fill_unused(r), 1'b0, '0);
          items++;
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending_vertices.size() == 0) begin
      $display("linear_blend_skinning_core verification clean");
    end else begin
      $display("linear_blend_skinning_core verification failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("linear_blend_skinning_core verification failed");
    $finish;
  end

endmodule
